// ===== hw/rtl/pdm_pkg.sv =====
// shared widths, register codes and saturation helpers for the drive mixer
`default_nettype none

package pdm_pkg;

   localparam int SpeedW    = 16;
   localparam int GainW     = 24;
   localparam int GainFracW = 16;
   localparam int SumW      = 32;
   localparam int LimitW    = 15;
   localparam int CsrIndexW = 3;
   localparam int CsrDataW  = 24;

   typedef enum logic [CsrIndexW-1:0] {
      CSR_KP          = 3'd0,
      CSR_KI_DT       = 3'd1,
      CSR_KD_OVER_DT  = 3'd2,
      CSR_BASE_SPEED  = 3'd3,
      CSR_WHEEL_LIMIT = 3'd4,
      CSR_TURN_LIMIT  = 3'd5
   } csr_index_type;

   localparam logic [GainW-1:0]         KpReset         = 24'd65536;
   localparam logic [GainW-1:0]         KiDtReset       = 24'd0;
   localparam logic [GainW-1:0]         KdOverDtReset   = 24'd1311;
   localparam logic signed [SpeedW-1:0] BaseSpeedReset  = 16'sd1229;
   localparam logic [LimitW-1:0]        WheelLimitReset = 15'd6144;
   localparam logic [LimitW-1:0]        TurnLimitReset  = 15'd4915;

   function automatic logic signed [SpeedW+1:0] ext18(input logic signed [SpeedW-1:0] x);
      ext18 = {{2{x[SpeedW-1]}}, x};
   endfunction

   function automatic logic signed [SpeedW-1:0] sat_s16(input logic signed [SpeedW+1:0] x);
      logic signed [SpeedW+1:0] hi_lim;
      logic signed [SpeedW+1:0] lo_lim;
      hi_lim = 18'sd32767;
      lo_lim = -18'sd32768;
      if (x > hi_lim) begin
         sat_s16 = 16'sh7fff;
      end else if (x < lo_lim) begin
         sat_s16 = 16'sh8000;
      end else begin
         sat_s16 = x[SpeedW-1:0];
      end
   endfunction

   // symmetric clamp to +/- lim
   function automatic logic signed [SpeedW-1:0] clamp_lim(input logic signed [SpeedW-1:0] x,
                                                         input logic [LimitW-1:0] lim);
      logic signed [SpeedW-1:0] hi_v;
      logic signed [SpeedW-1:0] lo_v;
      hi_v = signed'({1'b0, lim});
      lo_v = -hi_v;
      if (x < lo_v) begin
         clamp_lim = lo_v;
      end else if (x > hi_v) begin
         clamp_lim = hi_v;
      end else begin
         clamp_lim = x;
      end
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/pdm_gain_term.sv =====
// one gain multiply with floor shift and 16-bit saturation
`default_nettype none

module pdm_gain_term import pdm_pkg::*; (
   input  logic [GainW-1:0]         gain,
   input  logic signed [SumW-1:0]   value,
   output logic signed [SpeedW-1:0] term
);

   localparam int ProdW = GainW + SumW + 1;
   localparam int ShW   = ProdW - GainFracW;

   logic signed [ProdW-1:0] product;
   logic signed [ShW-1:0]   shifted;

   always_comb begin
      product = ProdW'($signed({1'b0, gain})) * ProdW'(value);
      // dropping the fraction bits of a two's complement value rounds toward minus infinity
      shifted = $signed(product[ProdW-1:GainFracW]);
      if (!shifted[ShW-1] && (|shifted[ShW-2:SpeedW-1])) begin
         term = 16'sh7fff;
      end else if (shifted[ShW-1] && !(&shifted[ShW-2:SpeedW-1])) begin
         term = 16'sh8000;
      end else begin
         term = shifted[SpeedW-1:0];
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/pid_differential_drive_mixer_unit.sv =====
// top level: pid correction and differential drive mixing of line error samples
`default_nettype none

// Takes one signed Q4.12 line error word per cycle, unless rsp_ready stalls
// the pipeline, and returns one word of linear speed, angular speed and the
// two clamped wheel speeds (all Q4.12). Each result passes through the input
// register, gain multiply, correction sum, wheel mixing and clamp, then the
// result register. The error sum and last error advance as each word is
// accepted. Gains are unsigned Q8.16 with the sample period folded in. The
// user must write registers through the csr port only while no words are in
// flight, as the block does not enforce it; out-of-range indexes are ignored.
module pid_differential_drive_mixer_unit import pdm_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic signed [SpeedW-1:0] req_line_error,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [SpeedW-1:0] rsp_linear_speed,
   output logic signed [SpeedW-1:0] rsp_turn_rate,
   output logic signed [SpeedW-1:0] rsp_left_wheel,
   output logic signed [SpeedW-1:0] rsp_right_wheel,
   input  logic                     csr_write_en,
   input  logic [CsrIndexW-1:0]     csr_index,
   input  logic [CsrDataW-1:0]      csr_wdata
);

   // configuration
   logic [GainW-1:0]         kp_ff, ki_dt_ff, kd_over_dt_ff;
   logic signed [SpeedW-1:0] base_speed_ff;
   logic [LimitW-1:0]        wheel_limit_ff, turn_limit_ff;

   // controller state
   logic signed [SumW-1:0]   error_sum_ff, error_sum_in;
   logic signed [SpeedW-1:0] last_error_ff;

   // pipeline
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic s1_valid_in, s2_valid_in, s3_valid_in, s4_valid_in, out_valid_in;
   logic s1_en, s2_en, s3_en, s4_en, out_en;
   logic accept;

   logic signed [SpeedW-1:0] s1_err_ff;
   logic signed [SumW-1:0]   s1_sum_ff;
   logic signed [SpeedW:0]   s1_diff_ff, s1_diff_in;

   logic signed [SpeedW-1:0] p_term, i_term, d_term;
   logic signed [SpeedW-1:0] s2_p_ff, s2_i_ff, s2_d_ff;

   logic signed [SpeedW-1:0] s3_u_ff, s3_u_in;
   logic signed [SpeedW-1:0] s4_left_ff, s4_left_in, s4_right_ff, s4_right_in;

   logic signed [SpeedW-1:0] out_lin_ff, out_lin_in, out_ang_ff, out_ang_in;
   logic signed [SpeedW-1:0] out_left_ff, out_right_ff;

   logic signed [SumW:0]     sum_wide;
   logic signed [SpeedW:0]   wheel_sum;
   logic signed [SpeedW-1:0] pi_sum;

   // stage enables, a stage loads when it is empty or its word moves on
   always_comb begin
      out_en    = !out_valid_ff || rsp_ready;
      s4_en     = !s4_valid_ff || out_en;
      s3_en     = !s3_valid_ff || s4_en;
      s2_en     = !s2_valid_ff || s3_en;
      s1_en     = !s1_valid_ff || s2_en;
      req_ready = s1_en;
      accept    = req_valid && s1_en;

      s1_valid_in  = s1_en  ? req_valid   : s1_valid_ff;
      s2_valid_in  = s2_en  ? s1_valid_ff : s2_valid_ff;
      s3_valid_in  = s3_en  ? s2_valid_ff : s3_valid_ff;
      s4_valid_in  = s4_en  ? s3_valid_ff : s4_valid_ff;
      out_valid_in = out_en ? s4_valid_ff : out_valid_ff;
   end

   // saturating error sum including the current sample
   always_comb begin
      sum_wide = {error_sum_ff[SumW-1], error_sum_ff}
               + {{(SumW-SpeedW+1){req_line_error[SpeedW-1]}}, req_line_error};
      if (sum_wide[SumW] != sum_wide[SumW-1]) begin
         error_sum_in = sum_wide[SumW] ? {1'b1, {(SumW-1){1'b0}}} : {1'b0, {(SumW-1){1'b1}}};
      end else begin
         error_sum_in = sum_wide[SumW-1:0];
      end
      s1_diff_in = {req_line_error[SpeedW-1], req_line_error}
                 - {last_error_ff[SpeedW-1], last_error_ff};
   end

   pdm_gain_term u_p_term (
      .gain  (kp_ff),
      .value ({{(SumW-SpeedW){s1_err_ff[SpeedW-1]}}, s1_err_ff}),
      .term  (p_term)
   );

   pdm_gain_term u_i_term (
      .gain  (ki_dt_ff),
      .value (s1_sum_ff),
      .term  (i_term)
   );

   pdm_gain_term u_d_term (
      .gain  (kd_over_dt_ff),
      .value ({{(SumW-SpeedW-1){s1_diff_ff[SpeedW]}}, s1_diff_ff}),
      .term  (d_term)
   );

   always_comb begin
      pi_sum      = sat_s16(ext18(s2_p_ff) + ext18(s2_i_ff));
      s3_u_in     = sat_s16(ext18(pi_sum) + ext18(s2_d_ff));
      s4_left_in  = clamp_lim(sat_s16(ext18(base_speed_ff) - ext18(s3_u_ff)), wheel_limit_ff);
      s4_right_in = clamp_lim(sat_s16(ext18(base_speed_ff) + ext18(s3_u_ff)), wheel_limit_ff);
      out_ang_in  = clamp_lim(sat_s16(ext18(s4_right_ff) - ext18(s4_left_ff)), turn_limit_ff);
      wheel_sum   = {s4_left_ff[SpeedW-1], s4_left_ff} + {s4_right_ff[SpeedW-1], s4_right_ff};
      // floored mean
      out_lin_in  = wheel_sum[SpeedW:1];
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         kp_ff          <= KpReset;
         ki_dt_ff       <= KiDtReset;
         kd_over_dt_ff  <= KdOverDtReset;
         base_speed_ff  <= BaseSpeedReset;
         wheel_limit_ff <= WheelLimitReset;
         turn_limit_ff  <= TurnLimitReset;
         error_sum_ff   <= '0;
         last_error_ff  <= '0;
         s1_valid_ff    <= 1'b0;
         s2_valid_ff    <= 1'b0;
         s3_valid_ff    <= 1'b0;
         s4_valid_ff    <= 1'b0;
         out_valid_ff   <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         s4_valid_ff  <= s4_valid_in;
         out_valid_ff <= out_valid_in;
         if (accept) begin
            error_sum_ff  <= error_sum_in;
            last_error_ff <= req_line_error;
         end
         if (csr_write_en) begin
            case (csr_index_type'(csr_index))
               CSR_KP:          kp_ff          <= csr_wdata[GainW-1:0];
               CSR_KI_DT:       ki_dt_ff       <= csr_wdata[GainW-1:0];
               CSR_KD_OVER_DT:  kd_over_dt_ff  <= csr_wdata[GainW-1:0];
               CSR_BASE_SPEED:  base_speed_ff  <= csr_wdata[SpeedW-1:0];
               CSR_WHEEL_LIMIT: wheel_limit_ff <= csr_wdata[LimitW-1:0];
               CSR_TURN_LIMIT:  turn_limit_ff  <= csr_wdata[LimitW-1:0];
               default: ;
            endcase
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_err_ff  <= req_line_error;
         s1_sum_ff  <= error_sum_in;
         s1_diff_ff <= s1_diff_in;
      end
      if (s2_en) begin
         s2_p_ff <= p_term;
         s2_i_ff <= i_term;
         s2_d_ff <= d_term;
      end
      if (s3_en) begin
         s3_u_ff <= s3_u_in;
      end
      if (s4_en) begin
         s4_left_ff  <= s4_left_in;
         s4_right_ff <= s4_right_in;
      end
      if (out_en) begin
         out_lin_ff   <= out_lin_in;
         out_ang_ff   <= out_ang_in;
         out_left_ff  <= s4_left_ff;
         out_right_ff <= s4_right_ff;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_linear_speed  = out_lin_ff;
   assign rsp_turn_rate     = out_ang_ff;
   assign rsp_left_wheel    = out_left_ff;
   assign rsp_right_wheel   = out_right_ff;

endmodule

`default_nettype wire
